// ----- rtl/dttp_pkg.sv -----
package dttp_pkg;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_PARSE = 2'd1,
        PH_GAP   = 2'd2,
        PH_DRAIN = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        STG_YEAR   = 3'd0,
        STG_MONTH  = 3'd1,
        STG_DAY    = 3'd2,
        STG_HOUR   = 3'd3,
        STG_MINUTE = 3'd4,
        STG_SECOND = 3'd5,
        STG_FRAC   = 3'd6,
        STG_DONE   = 3'd7
    } t_stage;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int unsigned ACC_W   = 20;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned SMALL_W = 7;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned BYTES_W = 16;

    localparam logic [BYTES_W-1:0] BYTES_MAX = 16'hFFFF;

    typedef struct packed {
        t_phase               phase;
        t_stage               stage;
        logic [CNT_W-1:0]     count;
        logic [ACC_W-1:0]     acc;
        logic [YEAR_W-1:0]    year;
        logic [SMALL_W-1:0]   month;
        logic [SMALL_W-1:0]   day;
        logic [SMALL_W-1:0]   hour;
        logic [SMALL_W-1:0]   minute;
        logic [SMALL_W-1:0]   second;
        logic [BYTES_W-1:0]   bytes;
    } t_state;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [SMALL_W-1:0]   month;
        logic [SMALL_W-1:0]   day;
        logic [SMALL_W-1:0]   hour;
        logic [SMALL_W-1:0]   minute;
        logic [SMALL_W-1:0]   second;
        logic [ACC_W-1:0]     micro;
        logic                 error;
        logic [BYTES_W-1:0]   bytes;
    } t_result;

    localparam t_state ST_RESET = '{
        phase:  PH_LEAD,
        stage:  STG_YEAR,
        count:  '0,
        acc:    '0,
        year:   '0,
        month:  '0,
        day:    '0,
        hour:   '0,
        minute: '0,
        second: '0,
        bytes:  '0
    };

    function automatic logic [CNT_W-1:0] digit_cap(input t_stage stage);
        logic [CNT_W-1:0] cap;
        case (stage)
            STG_YEAR: cap = 3'd4;
            STG_FRAC: cap = 3'd6;
            default:  cap = 3'd2;
        endcase
        return cap;
    endfunction

    function automatic logic [ACC_W-1:0] pad_scale(input logic [CNT_W-1:0] count);
        logic [ACC_W-1:0] scale;
        case (count)
            3'd0:    scale = 20'd1000000 & 20'hFFFFF;
            3'd1:    scale = 20'd100000;
            3'd2:    scale = 20'd10000;
            3'd3:    scale = 20'd1000;
            3'd4:    scale = 20'd100;
            3'd5:    scale = 20'd10;
            default: scale = 20'd1;
        endcase
        return scale;
    endfunction

endpackage

// ----- rtl/dttp_step.sv -----
module dttp_step (
    input  dttp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    output dttp_pkg::t_state  o_state,
    output dttp_pkg::t_result o_result
);

    logic                          w_active;
    logic                          w_is_digit;
    logic                          w_is_sep;
    logic                          w_is_space;
    logic                          w_is_colon;
    logic                          w_is_dot;
    logic                          w_in_date;
    logic                          w_err;
    logic                          w_full;
    logic [3:0]                    w_digit;
    logic [dttp_pkg::ACC_W-1:0]    w_acc_mac;
    logic [dttp_pkg::ACC_W-1:0]    w_prod;
    logic [dttp_pkg::BYTES_W-1:0]  w_bytes_inc;
    logic                          w_store;
    dttp_pkg::t_phase              w_phase;

    always_comb begin
        w_is_digit = i_byte inside {[dttp_pkg::CH_ZERO:dttp_pkg::CH_NINE]};
        w_is_sep   = i_byte inside {dttp_pkg::CH_DASH, dttp_pkg::CH_SLASH};
        w_is_space = (i_byte == dttp_pkg::CH_SPACE);
        w_is_colon = (i_byte == dttp_pkg::CH_COLON);
        w_is_dot   = (i_byte == dttp_pkg::CH_DOT);
        w_in_date  = i_state.stage inside {dttp_pkg::STG_YEAR, dttp_pkg::STG_MONTH,
                                           dttp_pkg::STG_DAY};
        w_digit    = i_byte[3:0] - dttp_pkg::CH_ZERO[3:0];
        w_active   = (i_state.phase == dttp_pkg::PH_PARSE)
                   || (((i_state.phase == dttp_pkg::PH_LEAD)
                        || (i_state.phase == dttp_pkg::PH_GAP)) && !w_is_space);
        w_err      = w_active && !(w_is_digit
                   || (w_is_sep && w_in_date)
                   || (w_is_space && w_in_date)
                   || (w_is_colon && ((i_state.stage == dttp_pkg::STG_HOUR)
                                      || (i_state.stage == dttp_pkg::STG_MINUTE)))
                   || (w_is_dot && (i_state.stage == dttp_pkg::STG_SECOND)));
        w_full     = (i_state.count >= dttp_pkg::digit_cap(i_state.stage));
        w_acc_mac  = dttp_pkg::ACC_W'({i_state.acc, 3'b000} + {i_state.acc, 1'b0}
                   + {{(dttp_pkg::ACC_W - 4){1'b0}}, w_digit});
        w_prod     = dttp_pkg::ACC_W'(i_state.acc * dttp_pkg::pad_scale(i_state.count));
        w_bytes_inc = (i_state.bytes == dttp_pkg::BYTES_MAX) ? i_state.bytes
                    : i_state.bytes + 16'd1;
    end

    // next phase
    always_comb begin
        w_phase = i_state.phase;
        if (w_active) begin
            if (w_err) begin
                w_phase = dttp_pkg::PH_DRAIN;
            end else if ((w_is_sep && (i_state.stage == dttp_pkg::STG_DAY))
                         || (w_is_space && w_in_date)) begin
                w_phase = dttp_pkg::PH_GAP;
            end else begin
                w_phase = dttp_pkg::PH_PARSE;
            end
        end
    end

    // field datapath
    always_comb begin
        o_state       = i_state;
        o_state.phase = w_phase;
        o_state.bytes = w_bytes_inc;
        w_store       = 1'b0;
        if (w_active && !w_err) begin
            if (w_is_digit) begin
                if (i_state.stage == dttp_pkg::STG_FRAC && w_full) begin
                    o_state.stage = dttp_pkg::STG_DONE;
                    o_state.count = '0;
                end else if (i_state.stage != dttp_pkg::STG_DONE) begin
                    if (w_full) begin
                        w_store       = 1'b1;
                        o_state.stage = dttp_pkg::t_stage'(i_state.stage + 3'd1);
                        o_state.acc   = {{(dttp_pkg::ACC_W - 4){1'b0}}, w_digit};
                        o_state.count = 3'd1;
                    end else begin
                        o_state.acc   = w_acc_mac;
                        o_state.count = i_state.count + 3'd1;
                    end
                end
            end else begin
                w_store       = 1'b1;
                o_state.acc   = '0;
                o_state.count = '0;
                o_state.stage = w_is_space ? dttp_pkg::STG_HOUR
                              : dttp_pkg::t_stage'(i_state.stage + 3'd1);
            end
        end
        if (w_store) begin
            case (i_state.stage)
                dttp_pkg::STG_YEAR:   o_state.year   = i_state.acc[dttp_pkg::YEAR_W-1:0];
                dttp_pkg::STG_MONTH:  o_state.month  = i_state.acc[dttp_pkg::SMALL_W-1:0];
                dttp_pkg::STG_DAY:    o_state.day    = i_state.acc[dttp_pkg::SMALL_W-1:0];
                dttp_pkg::STG_HOUR:   o_state.hour   = i_state.acc[dttp_pkg::SMALL_W-1:0];
                dttp_pkg::STG_MINUTE: o_state.minute = i_state.acc[dttp_pkg::SMALL_W-1:0];
                dttp_pkg::STG_SECOND: o_state.second = i_state.acc[dttp_pkg::SMALL_W-1:0];
                default: ;
            endcase
        end
    end

    // result on terminator: the open field closes into its slot
    always_comb begin
        o_result.year   = (i_state.stage == dttp_pkg::STG_YEAR)
                        ? i_state.acc[dttp_pkg::YEAR_W-1:0] : i_state.year;
        o_result.month  = (i_state.stage == dttp_pkg::STG_MONTH)
                        ? i_state.acc[dttp_pkg::SMALL_W-1:0] : i_state.month;
        o_result.day    = (i_state.stage == dttp_pkg::STG_DAY)
                        ? i_state.acc[dttp_pkg::SMALL_W-1:0] : i_state.day;
        o_result.hour   = (i_state.stage == dttp_pkg::STG_HOUR)
                        ? i_state.acc[dttp_pkg::SMALL_W-1:0] : i_state.hour;
        o_result.minute = (i_state.stage == dttp_pkg::STG_MINUTE)
                        ? i_state.acc[dttp_pkg::SMALL_W-1:0] : i_state.minute;
        o_result.second = (i_state.stage == dttp_pkg::STG_SECOND)
                        ? i_state.acc[dttp_pkg::SMALL_W-1:0] : i_state.second;
        case (i_state.stage)
            dttp_pkg::STG_FRAC: o_result.micro = w_prod;
            dttp_pkg::STG_DONE: o_result.micro = i_state.acc;
            default:            o_result.micro = '0;
        endcase
        o_result.error = (i_state.phase == dttp_pkg::PH_DRAIN);
        o_result.bytes = w_bytes_inc;
        if (o_result.error) begin
            o_result.year   = '0;
            o_result.month  = '0;
            o_result.day    = '0;
            o_result.hour   = '0;
            o_result.minute = '0;
            o_result.second = '0;
            o_result.micro  = '0;
        end
    end

endmodule

// ----- rtl/date_time_text_parser_core.sv -----
// Date and time text parser. Text bytes enter on the slave stream, one per transaction, and
// a zero byte ends each string; the block then emits one result transaction holding year,
// month, day, hour, minute, second, microseconds and the byte count of the string, with the
// error flag on tuser (value fields read zero when it is set). An input register feeds
// the field-update and result logic, which loads the output register on a terminator,
// so the block sustains one byte per clock unless a terminator waits on a stalled result.
// Only a terminator waits on a full output register; other bytes keep flowing while a result
// is stalled.
module date_time_text_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // text_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // year_value, month_value, day_value, hour_value, minute_value, second_value,
    // micro_value, bytes_used, zero fill
    output logic [87:0]  o_m_axis_tdata,
    output logic         o_m_axis_tuser    // parse_error
);

    logic               r_in_valid;
    logic               n_in_valid;
    logic [7:0]         r_in_byte;
    logic [7:0]         n_in_byte;
    dttp_pkg::t_state   r_state;
    dttp_pkg::t_state   n_state;
    logic               r_out_valid;
    logic               n_out_valid;
    dttp_pkg::t_result  r_out;
    dttp_pkg::t_result  n_out;

    dttp_pkg::t_state   w_step_state;
    dttp_pkg::t_result  w_step_result;
    logic               w_is_term;
    logic               w_fire;

    dttp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (w_step_state),
        .o_result (w_step_result)
    );

    always_comb begin
        w_is_term       = (r_in_byte == dttp_pkg::CH_NUL);
        w_fire          = r_in_valid && (!w_is_term || !r_out_valid || i_m_axis_tready);
        o_s_axis_tready = !r_in_valid || w_fire;

        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        if (o_s_axis_tready) begin
            n_in_valid = i_s_axis_tvalid;
            n_in_byte  = i_s_axis_tdata;
        end

        n_state = r_state;
        if (w_fire) begin
            n_state = w_is_term ? dttp_pkg::ST_RESET : w_step_state;
        end

        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out       = r_out;
        if (w_fire && w_is_term) begin
            n_out_valid = 1'b1;
            n_out       = w_step_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= dttp_pkg::ST_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte <= n_in_byte;
        r_out     <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.error;
    assign o_m_axis_tdata  = {3'b000, r_out.bytes, r_out.micro, r_out.second, r_out.minute,
                              r_out.hour, r_out.day, r_out.month, r_out.year};

endmodule

// ----- rtl/dttp_checker.sv -----
module dttp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [7:0]   i_s_axis_tdata,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [87:0]  o_m_axis_tdata,
    input logic         o_m_axis_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output backpressure");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[68:0] == 69'd0)
        else $error("error result with nonzero fields");

    // microseconds stay below one second and every string counts its terminator
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[68:49] <= 20'd999999
            && o_m_axis_tdata[84:69] != 16'd0)
        else $error("result field out of range");

endmodule

bind date_time_text_parser_core dttp_checker u_dttp_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned TAIL_CYCLES    = 16;
    localparam int unsigned FORMED_BYTES   = 1100;
    localparam int unsigned NOISE_BYTES    = 350;
    localparam int unsigned LONG_SPACES    = 200;
    localparam int unsigned REPORT_MAX     = 10;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;    // text_byte
    logic         m_tvalid;
    logic         m_tready;
    // year[13:0], month[20:14], day[27:21], hour[34:28], minute[41:35], second[48:42],
    // micro[68:49], bytes_used[84:69], zero fill
    logic [87:0]  m_tdata;
    logic         m_tuser;    // parse_error

    date_time_text_parser_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    dttp_pkg::t_phase                   text_phase;
    dttp_pkg::t_stage                   text_stage;
    logic [dttp_pkg::CNT_W-1:0]         digit_cnt;
    logic [dttp_pkg::ACC_W-1:0]         digit_acc;
    logic [dttp_pkg::YEAR_W-1:0]        year_q;
    logic [dttp_pkg::SMALL_W-1:0]       month_q;
    logic [dttp_pkg::SMALL_W-1:0]       day_q;
    logic [dttp_pkg::SMALL_W-1:0]       hour_q;
    logic [dttp_pkg::SMALL_W-1:0]       minute_q;
    logic [dttp_pkg::SMALL_W-1:0]       second_q;
    logic [dttp_pkg::BYTES_W-1:0]       byte_cnt;

    dttp_pkg::t_result  pending_stamps[$];
    logic [7:0]         text_buf[$];

    int unsigned strings_sent   = 0;
    int unsigned bytes_sent     = 0;
    int unsigned stamps_checked = 0;
    int unsigned error_stamps   = 0;
    int unsigned fail_count     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned stall_left     = 0;
    int unsigned recv_stall_pct = 20;
    bit          send_idle_on   = 1'b1;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void set_pace();
        if ($urandom_range(0, 4) == 0) begin
            send_idle_on   = 1'b0;
            recv_stall_pct = 0;
        end else begin
            send_idle_on   = 1'b1;
            recv_stall_pct = $urandom_range(5, 40);
        end
    endfunction

    function automatic void clear_parser();
        text_phase = dttp_pkg::PH_LEAD;
        text_stage = dttp_pkg::STG_YEAR;
        digit_cnt  = '0;
        digit_acc  = '0;
        year_q     = '0;
        month_q    = '0;
        day_q      = '0;
        hour_q     = '0;
        minute_q   = '0;
        second_q   = '0;
        byte_cnt   = '0;
    endfunction

    function automatic void close_field();
        logic [31:0] v;
        int          n;
        v = 32'(digit_acc);
        if (text_stage == dttp_pkg::STG_FRAC) begin
            for (n = digit_cnt; n < 6; n++)
                v = v * 10;
            digit_acc  = v[dttp_pkg::ACC_W-1:0];
            digit_cnt  = '0;
            text_stage = dttp_pkg::STG_DONE;
            return;
        end
        case (text_stage)
            dttp_pkg::STG_YEAR:   year_q   = v[dttp_pkg::YEAR_W-1:0];
            dttp_pkg::STG_MONTH:  month_q  = v[dttp_pkg::SMALL_W-1:0];
            dttp_pkg::STG_DAY:    day_q    = v[dttp_pkg::SMALL_W-1:0];
            dttp_pkg::STG_HOUR:   hour_q   = v[dttp_pkg::SMALL_W-1:0];
            dttp_pkg::STG_MINUTE: minute_q = v[dttp_pkg::SMALL_W-1:0];
            dttp_pkg::STG_SECOND: second_q = v[dttp_pkg::SMALL_W-1:0];
            default:              return;
        endcase
        digit_acc  = '0;
        digit_cnt  = '0;
        text_stage = dttp_pkg::t_stage'(text_stage + 1);
    endfunction

    function automatic void parse_char(input logic [7:0] b);
        int          cap;
        logic [31:0] sum;
        if (b >= dttp_pkg::CH_ZERO && b <= dttp_pkg::CH_NINE) begin
            if (text_stage == dttp_pkg::STG_DONE)
                return;
            cap = (text_stage == dttp_pkg::STG_YEAR) ? 4
                : (text_stage == dttp_pkg::STG_FRAC) ? 6 : 2;
            if (digit_cnt >= cap) begin
                close_field();
                if (text_stage == dttp_pkg::STG_DONE)
                    return;
            end
            sum       = 32'(digit_acc) * 10 + 32'(b - dttp_pkg::CH_ZERO);
            digit_acc = sum[dttp_pkg::ACC_W-1:0];
            digit_cnt = digit_cnt + 1'b1;
            return;
        end
        if (b == dttp_pkg::CH_DASH || b == dttp_pkg::CH_SLASH) begin
            if (text_stage <= dttp_pkg::STG_DAY) begin
                close_field();
                if (text_stage == dttp_pkg::STG_HOUR)
                    text_phase = dttp_pkg::PH_GAP;
                return;
            end
        end else if (b == dttp_pkg::CH_SPACE) begin
            if (text_stage <= dttp_pkg::STG_DAY) begin
                close_field();
                digit_acc  = '0;
                digit_cnt  = '0;
                text_stage = dttp_pkg::STG_HOUR;
                text_phase = dttp_pkg::PH_GAP;
                return;
            end
        end else if (b == dttp_pkg::CH_COLON) begin
            if (text_stage == dttp_pkg::STG_HOUR || text_stage == dttp_pkg::STG_MINUTE) begin
                close_field();
                return;
            end
        end else if (b == dttp_pkg::CH_DOT) begin
            if (text_stage == dttp_pkg::STG_SECOND) begin
                close_field();
                return;
            end
        end
        text_phase = dttp_pkg::PH_DRAIN;
    endfunction

    function automatic void advance_parser(input logic [7:0] b);
        dttp_pkg::t_result stamp;
        bit                in_err;
        if (byte_cnt != dttp_pkg::BYTES_MAX)
            byte_cnt = byte_cnt + 1'b1;
        if (b == dttp_pkg::CH_NUL) begin
            in_err = (text_phase == dttp_pkg::PH_DRAIN);
            if (!in_err && text_stage != dttp_pkg::STG_DONE)
                close_field();
            stamp = '0;
            if (!in_err) begin
                stamp.year   = year_q;
                stamp.month  = month_q;
                stamp.day    = day_q;
                stamp.hour   = hour_q;
                stamp.minute = minute_q;
                stamp.second = second_q;
                if (text_stage == dttp_pkg::STG_DONE)
                    stamp.micro = digit_acc;
            end
            stamp.error = in_err;
            stamp.bytes = byte_cnt;
            pending_stamps.push_back(stamp);
            clear_parser();
            return;
        end
        case (text_phase)
            dttp_pkg::PH_LEAD, dttp_pkg::PH_GAP: begin
                if (b != dttp_pkg::CH_SPACE) begin
                    text_phase = dttp_pkg::PH_PARSE;
                    parse_char(b);
                end
            end
            dttp_pkg::PH_PARSE: parse_char(b);
            default: ;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        bytes_sent++;
        advance_parser(b);
    endtask

    task automatic send_buf();
        foreach (text_buf[i])
            send_byte(text_buf[i]);
        send_byte(dttp_pkg::CH_NUL);
        strings_sent++;
    endtask

    task automatic send_text(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_buf();
    endtask

    function automatic void add_digits(input int n);
        repeat (n)
            text_buf.push_back(8'(dttp_pkg::CH_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic int field_len(input int usual, input int hi);
        return ($urandom_range(0, 9) < 8) ? usual : $urandom_range(0, hi);
    endfunction

    function automatic logic [7:0] date_sep();
        return $urandom_range(0, 1) ? dttp_pkg::CH_DASH : dttp_pkg::CH_SLASH;
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 6))
            0, 1:    return 8'($urandom_range(1, 255));
            2:       return 8'(dttp_pkg::CH_ZERO + $urandom_range(0, 9));
            3:       return dttp_pkg::CH_DASH;
            4:       return dttp_pkg::CH_SLASH;
            5:       return $urandom_range(0, 1) ? dttp_pkg::CH_COLON : dttp_pkg::CH_DOT;
            default: return dttp_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic void build_well_formed();
        int depth;
        int k;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            add_digits($urandom_range(0, 24));
            return;
        end
        repeat ($urandom_range(0, 2))
            text_buf.push_back(dttp_pkg::CH_SPACE);
        depth = $urandom_range(1, 7);
        add_digits(field_len(4, 5));
        if (depth > 1) begin
            text_buf.push_back(date_sep());
            add_digits(field_len(2, 3));
        end
        if (depth > 2) begin
            text_buf.push_back(date_sep());
            add_digits(field_len(2, 3));
        end
        if (depth > 3) begin
            k = $urandom_range(0, 5);
            if (k < 4) begin
                repeat ($urandom_range(1, 3))
                    text_buf.push_back(dttp_pkg::CH_SPACE);
            end else begin
                text_buf.push_back(date_sep());
                if (k == 5)
                    text_buf.push_back(dttp_pkg::CH_SPACE);
            end
            add_digits(field_len(2, 3));
        end
        if (depth > 4) begin
            text_buf.push_back(dttp_pkg::CH_COLON);
            add_digits(field_len(2, 3));
        end
        if (depth > 5) begin
            text_buf.push_back(dttp_pkg::CH_COLON);
            add_digits(field_len(2, 3));
        end
        if (depth > 6) begin
            text_buf.push_back(dttp_pkg::CH_DOT);
            add_digits($urandom_range(0, 8));
        end
    endfunction

    function automatic void check_stamp();
        dttp_pkg::t_result got;
        dttp_pkg::t_result want;
        got.year   = m_tdata[13:0];
        got.month  = m_tdata[20:14];
        got.day    = m_tdata[27:21];
        got.hour   = m_tdata[34:28];
        got.minute = m_tdata[41:35];
        got.second = m_tdata[48:42];
        got.micro  = m_tdata[68:49];
        got.bytes  = m_tdata[84:69];
        got.error  = m_tuser;
        if (pending_stamps.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("unexpected result at %0t: bytes=%0d err=%0b",
                         $realtime, got.bytes, got.error);
            return;
        end
        want = pending_stamps.pop_front();
        stamps_checked++;
        if (want.error)
            error_stamps++;
        if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
            got.hour !== want.hour || got.minute !== want.minute ||
            got.second !== want.second || got.micro !== want.micro ||
            got.error !== want.error || got.bytes !== want.bytes) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
                $display("mismatch at %0t: exp %0d-%0d-%0d %0d:%0d:%0d.%06d err=%0b n=%0d",
                         $realtime, want.year, want.month, want.day, want.hour,
                         want.minute, want.second, want.micro, want.error, want.bytes);
                $display("                 got %0d-%0d-%0d %0d:%0d:%0d.%06d err=%0b n=%0d",
                         got.year, got.month, got.day, got.hour,
                         got.minute, got.second, got.micro, got.error, got.bytes);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            check_stamp();
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < recv_stall_pct) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        string texts[$];
        texts = '{"", "2024-03-15 12:34:56.789", "9999/99/99 99:99:99.999999",
                  "  7-8-9", "2024 1:2", "20240315235959123456789",
                  "1-2-3-4:5:6.", "12:30", "2024-1-2 3-4", "5.5", "x", "   ",
                  "1/2/3 4:5:6 7", "2024-03-15   08:09:10.1234567", "/-/"};
        foreach (texts[i])
            send_text(texts[i]);
        text_buf = '{8'h01, 8'h80, 8'hFF};
        send_buf();
    endtask

    task automatic test_well_formed();
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < FORMED_BYTES) begin
            set_pace();
            build_well_formed();
            if ($urandom_range(0, 9) < 2 && text_buf.size() > 0)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = noise_char();
            send_buf();
        end
    endtask

    task automatic test_noise();
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < NOISE_BYTES) begin
            set_pace();
            text_buf.delete();
            repeat ($urandom_range(0, 12))
                text_buf.push_back(noise_char());
            send_buf();
        end
    endtask

    task automatic test_long_string();
        string tail;
        tail           = "1999-12-31";
        send_idle_on   = 1'b0;
        recv_stall_pct = 0;
        text_buf.delete();
        repeat (LONG_SPACES)
            text_buf.push_back(dttp_pkg::CH_SPACE);
        for (int i = 0; i < tail.len(); i++)
            text_buf.push_back(tail[i]);
        send_buf();
        recv_stall_pct = 20;
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        m_tready <= 1'b0;
        clear_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_well_formed();
        test_noise();
        test_long_string();

        s_tvalid <= 1'b0;
        while (pending_stamps.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d strings in %0d bytes; checked %0d results, %0d with parse error,",
                 strings_sent, bytes_sent, stamps_checked, error_stamps);
        $display("over directed, well-formed, noisy and long padded text; %0d mismatches.",
                 fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
